[hw/rtl/bmhq_pkg.sv]
package bmhq_pkg;

	localparam int CAPACITY_DEF   = 128;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_DN_ROOT,
		ST_DN_LAST,
		ST_DN_CHK,
		ST_DN_LEFT,
		ST_DN_RIGHT,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		logic [1:0]         status;
		logic [7:0]         count;
	} rsp_t;

endpackage

[hw/rtl/binary_max_heap_queue.sv]
// Insert: the value enters at the new last position and climbs while its parent is smaller.
// Delete: the root is taken, the last entry moves to the root and sinks below any larger child.
// A full insert or an empty delete goes straight to the result.
// One item at a time: the next item is taken in the cycle after the result is loaded; the heap
// store (one read and one write port, registered read) sets the pace. Reset clears sequencer,
// entry count and result valid; the store is not cleared, only entries up to the count are read.
module binary_max_heap_queue #(
	parameter int CAPACITY   = bmhq_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bmhq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bmhq_pkg::rsp_t rsp
);

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	bmhq_pkg::state_t  state_q, state_d;
	bmhq_pkg::status_t status_q, status_d;
	logic [PW-1:0]     count_q, count_d;
	logic [PW-1:0]     pos_q, pos_d;
	data_t             val_q, val_d;
	data_t             left_q, left_d;
	data_t             removed_q, removed_d;
	logic              rsp_valid_q;
	bmhq_pkg::rsp_t    rsp_q;
	logic              rsp_load;
	logic              accept;

	// heap store, position p lives at index p-1
	data_t             mem [CAPACITY];
	data_t             rdata_q;
	logic [PW-1:0]     rd_pos, wr_pos, rd_off, wr_off;
	logic              we;
	data_t             wdata;

	logic [PW:0]       lpos, rpos, cnt_ext;
	data_t             big_val;
	logic [PW-1:0]     big_pos;
	logic [DATA_WIDTH+31:0] in_wide, rem_wide;
	logic [PW+7:0]     cnt_wide;
	bmhq_pkg::rsp_t    rsp_d;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != bmhq_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign lpos    = {pos_q, 1'b0};
	assign rpos    = {pos_q, 1'b1};
	assign cnt_ext = {1'b0, count_q};

	// low DATA_WIDTH bits of the zero-extended 32-bit value are taken as a signed number
	assign in_wide  = {{DATA_WIDTH{1'b0}}, req.value};
	assign rem_wide = {{32{removed_q[DATA_WIDTH-1]}}, removed_q};
	assign cnt_wide = {8'd0, count_q};

	assign rd_off = rd_pos - 1'b1;
	assign wr_off = wr_pos - 1'b1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_off[AW-1:0]] <= wdata;
		end
		rdata_q <= mem[rd_off[AW-1:0]];
	end

	always_comb begin
		rsp_d.removed_value = rem_wide[31:0];
		rsp_d.status        = status_q;
		rsp_d.count         = cnt_wide[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmhq_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		val_q     <= val_d;
		left_q    <= left_d;
		removed_q <= removed_d;
		status_q  <= status_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pos_d     = pos_q;
		val_d     = val_q;
		left_d    = left_q;
		removed_d = removed_q;
		status_d  = status_q;
		rsp_load  = 1'b0;
		rd_pos    = PW'(1);
		we        = 1'b0;
		wr_pos    = pos_q;
		wdata     = val_q;
		big_val   = left_q;
		big_pos   = lpos[PW-1:0];

		unique case (state_q)
			bmhq_pkg::ST_IDLE: begin
				// root is read every idle cycle so a delete finds it ready
				if (accept) begin
					removed_d = '0;
					status_d  = bmhq_pkg::STATUS_OK;
					if (req.cmd == bmhq_pkg::CMD_INSERT) begin
						if (count_q == PW'(CAPACITY)) begin
							status_d = bmhq_pkg::STATUS_FULL;
							state_d  = bmhq_pkg::ST_DONE;
						end else begin
							count_d = count_q + 1'b1;
							pos_d   = count_q + 1'b1;
							val_d   = in_wide[DATA_WIDTH-1:0];
							state_d = bmhq_pkg::ST_UP_CHK;
						end
					end else begin
						if (count_q == '0) begin
							status_d = bmhq_pkg::STATUS_EMPTY;
							state_d  = bmhq_pkg::ST_DONE;
						end else begin
							count_d = count_q - 1'b1;
							state_d = bmhq_pkg::ST_DN_ROOT;
						end
					end
				end
			end
			bmhq_pkg::ST_UP_CHK: begin
				if (pos_q == PW'(1)) begin
					state_d = bmhq_pkg::ST_WRITE;
				end else begin
					rd_pos  = pos_q >> 1;
					state_d = bmhq_pkg::ST_UP_CMP;
				end
			end
			bmhq_pkg::ST_UP_CMP: begin
				// hole moves up: parent drops into the current slot
				if (rdata_q < val_q) begin
					we      = 1'b1;
					wdata   = rdata_q;
					pos_d   = pos_q >> 1;
					state_d = bmhq_pkg::ST_UP_CHK;
				end else begin
					state_d = bmhq_pkg::ST_WRITE;
				end
			end
			bmhq_pkg::ST_DN_ROOT: begin
				removed_d = rdata_q;
				rd_pos    = count_q + 1'b1;
				state_d   = bmhq_pkg::ST_DN_LAST;
			end
			bmhq_pkg::ST_DN_LAST: begin
				val_d   = rdata_q;
				pos_d   = PW'(1);
				state_d = bmhq_pkg::ST_DN_CHK;
			end
			bmhq_pkg::ST_DN_CHK: begin
				if (lpos <= cnt_ext) begin
					rd_pos  = lpos[PW-1:0];
					state_d = bmhq_pkg::ST_DN_LEFT;
				end else begin
					state_d = bmhq_pkg::ST_WRITE;
				end
			end
			bmhq_pkg::ST_DN_LEFT: begin
				left_d = rdata_q;
				if (rpos <= cnt_ext) begin
					rd_pos  = rpos[PW-1:0];
					state_d = bmhq_pkg::ST_DN_RIGHT;
				end else if (val_q < rdata_q) begin
					we      = 1'b1;
					wdata   = rdata_q;
					pos_d   = lpos[PW-1:0];
					state_d = bmhq_pkg::ST_DN_CHK;
				end else begin
					state_d = bmhq_pkg::ST_WRITE;
				end
			end
			bmhq_pkg::ST_DN_RIGHT: begin
				// right child wins only when strictly greater
				if (rdata_q > left_q) begin
					big_val = rdata_q;
					big_pos = rpos[PW-1:0];
				end
				if (val_q < big_val) begin
					we      = 1'b1;
					wdata   = big_val;
					pos_d   = big_pos;
					state_d = bmhq_pkg::ST_DN_CHK;
				end else begin
					state_d = bmhq_pkg::ST_WRITE;
				end
			end
			bmhq_pkg::ST_WRITE: begin
				we      = 1'b1;
				state_d = bmhq_pkg::ST_DONE;
			end
			bmhq_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = bmhq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bmhq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int CAP            = bmhq_pkg::CAPACITY_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 64;

	typedef struct packed {
		logic           typed;
		bmhq_pkg::req_t item;
		bmhq_pkg::rsp_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	bmhq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	bmhq_pkg::rsp_t rsp;

	binary_max_heap_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow heap, one-based like the block
	logic signed [31:0] heap_model [1:CAP];
	int unsigned heap_size = 0;
	bmhq_pkg::rsp_t pending_rsp [$];

	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int full_hits = 0;
	int empty_hits = 0;
	int peak_size = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit bursts_on = 1'b1;
	bmhq_pkg::rsp_t got_rsp;
	bmhq_pkg::rsp_t want_rsp;

	// directed items: extremes, ties, full-range values, delete from empty
	step_t dir_table [0:24] = '{
		'{1'b1, '{bmhq_pkg::CMD_DELETE, 32'sh5a5a_a5a5},
			'{32'sd0, bmhq_pkg::STATUS_EMPTY, 8'd0}},
		'{1'b1, '{bmhq_pkg::CMD_INSERT, 32'sh7fff_ffff},
			'{32'sd0, bmhq_pkg::STATUS_OK, 8'd1}},
		'{1'b1, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000},
			'{32'sh7fff_ffff, bmhq_pkg::STATUS_OK, 8'd0}},
		'{1'b1, '{bmhq_pkg::CMD_INSERT, 32'sh8000_0000},
			'{32'sd0, bmhq_pkg::STATUS_OK, 8'd1}},
		'{1'b1, '{bmhq_pkg::CMD_INSERT, 32'sh7fff_ffff},
			'{32'sd0, bmhq_pkg::STATUS_OK, 8'd2}},
		'{1'b1, '{bmhq_pkg::CMD_DELETE, 32'shffff_ffff},
			'{32'sh7fff_ffff, bmhq_pkg::STATUS_OK, 8'd1}},
		'{1'b1, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000},
			'{32'sh8000_0000, bmhq_pkg::STATUS_OK, 8'd0}},
		'{1'b1, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000},
			'{32'sd0, bmhq_pkg::STATUS_EMPTY, 8'd0}},
		'{1'b0, '{bmhq_pkg::CMD_INSERT, 32'sh0000_0000}, '0},
		'{1'b0, '{bmhq_pkg::CMD_INSERT, 32'shffff_ffff}, '0},
		'{1'b0, '{bmhq_pkg::CMD_INSERT, 32'sh0000_0005}, '0},
		'{1'b0, '{bmhq_pkg::CMD_INSERT, 32'sh0000_0005}, '0},
		'{1'b0, '{bmhq_pkg::CMD_INSERT, 32'sh0000_0005}, '0},
		'{1'b0, '{bmhq_pkg::CMD_INSERT, 32'sh7fff_ffff}, '0},
		'{1'b0, '{bmhq_pkg::CMD_INSERT, 32'sh8000_0000}, '0},
		'{1'b0, '{bmhq_pkg::CMD_INSERT, 32'shffff_ffff}, '0},
		'{1'b0, '{bmhq_pkg::CMD_DELETE, 32'shffff_ffff}, '0},
		'{1'b0, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000}, '0},
		'{1'b0, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000}, '0},
		'{1'b0, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000}, '0},
		'{1'b0, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000}, '0},
		'{1'b0, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000}, '0},
		'{1'b0, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000}, '0},
		'{1'b0, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000}, '0},
		'{1'b1, '{bmhq_pkg::CMD_DELETE, 32'sh0000_0000},
			'{32'sd0, bmhq_pkg::STATUS_EMPTY, 8'd0}}
	};

	function automatic bmhq_pkg::rsp_t heap_apply(input bmhq_pkg::req_t item);
		bmhq_pkg::rsp_t r;
		int unsigned pos;
		int unsigned kid;
		logic signed [31:0] tmp;
		r = '0;
		r.status = bmhq_pkg::STATUS_OK;
		if (item.cmd == bmhq_pkg::CMD_INSERT) begin
			if (heap_size >= CAP) begin
				r.status = bmhq_pkg::STATUS_FULL;
			end else begin
				heap_size++;
				heap_model[heap_size] = item.value;
				pos = heap_size;
				// climb while the parent is strictly smaller
				while (pos > 1 && heap_model[pos / 2] < heap_model[pos]) begin
					tmp = heap_model[pos / 2];
					heap_model[pos / 2] = heap_model[pos];
					heap_model[pos] = tmp;
					pos = pos / 2;
				end
			end
		end else if (heap_size == 0) begin
			r.status = bmhq_pkg::STATUS_EMPTY;
		end else begin
			r.removed_value = heap_model[1];
			heap_model[1] = heap_model[heap_size];
			heap_size--;
			pos = 1;
			while (pos <= heap_size / 2) begin
				kid = 2 * pos;
				// right child only if strictly greater than left
				if (kid + 1 <= heap_size && heap_model[kid + 1] > heap_model[kid])
					kid = kid + 1;
				if (heap_model[pos] < heap_model[kid]) begin
					tmp = heap_model[pos];
					heap_model[pos] = heap_model[kid];
					heap_model[kid] = tmp;
					pos = kid;
				end else begin
					break;
				end
			end
		end
		r.count = heap_size[7:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
	endtask

	task automatic send_item(input logic cmd, input logic signed [31:0] value,
			input bit typed, input bmhq_pkg::rsp_t want);
		bmhq_pkg::req_t item;
		bmhq_pkg::rsp_t model_rsp;
		bit taken;
		item.cmd = cmd;
		item.value = value;
		req_valid <= 1'b1;
		req <= item;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end
		model_rsp = heap_apply(item);
		pending_rsp.push_back(typed ? want : model_rsp);
		items_sent++;
		if (model_rsp.status == bmhq_pkg::STATUS_FULL)
			full_hits++;
		if (model_rsp.status == bmhq_pkg::STATUS_EMPTY)
			empty_hits++;
		if (heap_size > peak_size)
			peak_size = heap_size;
	endtask

	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'sh7fff_ffff;
			1: v = 32'sh8000_0000;
			2, 3: begin
				// narrow range, lots of equal keys
				v = $urandom_range(0, 15);
				v = v - 32'sd8;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_random(input int insert_pct);
		logic cmd;
		cmd = ($urandom_range(0, 99) < insert_pct) ? bmhq_pkg::CMD_INSERT
			: bmhq_pkg::CMD_DELETE;
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		send_item(cmd, pick_value(), 1'b0, '0);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!bursts_on) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// handshake inputs are stable between edges, so sample at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				got_rsp = rsp;
				results_seen++;
				if (pending_rsp.size() == 0) begin
					report_mismatch("unexpected item", got_rsp.removed_value, '0);
				end else begin
					want_rsp = pending_rsp.pop_front();
					if (got_rsp.removed_value !== want_rsp.removed_value)
						report_mismatch("removed_value", got_rsp.removed_value,
							want_rsp.removed_value);
					if (got_rsp.status !== want_rsp.status)
						report_mismatch("status", 32'(got_rsp.status),
							32'(want_rsp.status));
					if (got_rsp.count !== want_rsp.count)
						report_mismatch("count", 32'(got_rsp.count), 32'(want_rsp.count));
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding",
					$time, idle_cycles, pending_rsp.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			send_item(dir_table[i].item.cmd, dir_table[i].item.value,
				dir_table[i].typed, dir_table[i].want);

		// fill to capacity, then push against the full heap
		while (heap_size < CAP)
			send_random(92);
		repeat (6) send_random(100);
		wait_for_results();

		// drain, then hit the empty heap a few times
		while (heap_size > 0)
			send_random(8);
		repeat (4) send_random(0);

		for (int i = 0; i < 350; i++) begin
			if (i % 50 == 0)
				bursts_on <= ($urandom_range(0, 3) != 0);
			send_random(heap_size < 64 ? 60 : 40);
		end

		// tail with no idling on either side
		bursts_on <= 1'b0;
		repeat (150) send_random(55);

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items, checked %0d results; peak heap size %0d.",
			items_sent, results_seen, peak_size);
		$display("Full-heap inserts: %0d, empty-heap deletes: %0d, mismatches: %0d.",
			full_hits, empty_hits, errors);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
